// File: design/qlsf_pkg.sv
// Shared types, constants and term tables of the quadratic least-squares fit.
package qlsf_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int XW = 12;    // x, signed Q2.10
  localparam int YW = 16;    // y, signed Q4.12
  localparam int CW = 32;    // coefficients, signed Q16.16
  localparam int SW = 3;     // status code
  localparam int WW = 128;   // wide solver word
  localparam int LW = 32;    // limb of the shared multiplier
  localparam int MW = 33;    // signed multiplier operand
  localparam int PW = 66;    // multiplier product
  localparam int LAST_LIMB = 9;

  typedef enum logic [SW-1:0] {
    ST_OK      = 3'd0,
    ST_FEW     = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_NOTUNIQ = 3'd3,
    ST_DEGEN   = 3'd4
  } fit_status_t;

  // Solver operands: power sums, point count, moment sums, unity
  typedef enum logic [3:0] {
    OP_X4, OP_X3, OP_X2, OP_X1, OP_N, OP_X2Y, OP_XY, OP_Y, OP_ONE
  } opnd_t;

  // Quantities built by the solver
  typedef enum logic [2:0] {
    Q_DET, Q_DA, Q_DB, Q_DC, Q_QD
  } quant_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PT, S_CHK, S_LOAD, S_MUL, S_NEXT, S_DECIDE, S_DSET, S_DIV, S_DFIN, S_DONE
  } state_t;

  // Column used by each row in one of the six determinant terms
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] r);
    logic [5:0] cols;
    case (t)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      default: cols = {2'd0, 2'd1, 2'd2};
    endcase
    return cols[{r, 1'b0} +: 2];
  endfunction

  // Term subtracts from the quantity
  function automatic logic term_neg(input quant_t q, input logic [2:0] t);
    if (q == Q_QD) return (t == 3'd1);
    return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

  // Last term index of a quantity
  function automatic logic [2:0] term_last(input quant_t q);
    return (q == Q_QD) ? 3'd1 : 3'd5;
  endfunction

  // Operand of factor s of term t of quantity q
  function automatic opnd_t term_opnd(input quant_t q, input logic [2:0] t,
                                      input logic [1:0] s);
    logic [1:0] c;
    c = perm_col(t, s);
    if (q == Q_QD) begin
      if (s == 2'd2) return OP_ONE;
      if (t == 3'd0) return (s == 2'd0) ? OP_X4 : OP_X2;
      return OP_X3;
    end
    if (q != Q_DET && {1'b0, c} == 3'(q) - 3'd1)
      return opnd_t'(4'(OP_X2Y) + 4'(s));
    return opnd_t'(4'(s) + 4'(c));
  endfunction

  // Limb pair of each partial product of a 128-bit modular multiply
  function automatic logic [1:0] limb_a(input logic [3:0] m);
    case (m) inside
      4'd0, 4'd1, 4'd3, 4'd6: return 2'd0;
      4'd2, 4'd4, 4'd7:       return 2'd1;
      4'd5, 4'd8:             return 2'd2;
      default:                return 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] limb_b(input logic [3:0] m);
    case (m) inside
      4'd1, 4'd4, 4'd8: return 2'd1;
      4'd3, 4'd7:       return 2'd2;
      4'd6:             return 2'd3;
      default:          return 2'd0;
    endcase
  endfunction

endpackage

// File: design/quadratic_least_squares_fit.sv
// Top level: point accumulation and normal-equation solve of the quadratic fit.
// Each point takes a transfer plus six steps of the shared 33x33 multiplier
// forming x^2, xy, x^4, x^3 and x^2 y. A point marked last then starts the solve:
// 26 determinant terms, each two 128-bit modular products of ten limb multiplies on
// the same multiplier, then up to three 128-step restoring divisions; fewer than
// three points skip the solve. Points are taken again as soon as the result sits
// in the output register; the result of a following solve waits until the earlier
// result has been transferred.
module quadratic_least_squares_fit #(
  parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qlsf_pkg::XW-1:0]    in_x_value,
  input  logic signed [qlsf_pkg::YW-1:0]    in_y_value,
  input  logic                              in_last_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qlsf_pkg::CW-1:0]    out_coef_square,
  output logic signed [qlsf_pkg::CW-1:0]    out_coef_linear,
  output logic signed [qlsf_pkg::CW-1:0]    out_coef_constant,
  output logic [qlsf_pkg::SW-1:0]           out_fit_status
);
  import qlsf_pkg::*;

  localparam int LG    = $clog2(MAX_POINTS);
  localparam int CNTW  = $clog2(MAX_POINTS + 1);
  localparam int SX4W  = 46 + LG;
  localparam int SX3W  = 35 + LG;
  localparam int SX2W  = 24 + LG;
  localparam int SX1W  = 13 + LG;
  localparam int SYW   = 17 + LG;
  localparam int SXYW  = 28 + LG;
  localparam int SX2YW = 39 + LG;
  localparam int X2W   = 24;

  state_t state_r, state_nxt;

  logic [2:0]                step_r;
  logic signed [XW-1:0]      x_r;
  logic signed [YW-1:0]      y_r;
  logic                      last_r;
  logic signed [X2W-1:0]     x2_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [SX4W-1:0]    sum_x4_r;
  logic signed [SX3W-1:0]    sum_x3_r;
  logic signed [SX2W-1:0]    sum_x2_r;
  logic signed [SX1W-1:0]    sum_x1_r;
  logic signed [SYW-1:0]     sum_y_r;
  logic signed [SXYW-1:0]    sum_xy_r;
  logic signed [SX2YW-1:0]   sum_x2y_r;
  logic [CNTW-1:0]           cnt_r;

  quant_t                    quant_r;
  logic [2:0]                term_r;
  logic                      stage_r;
  logic [3:0]                mstep_r;
  logic [1:0]                sh_r;
  logic [WW-1:0]             opa_r, opb_r, acc_r;
  logic [WW-1:0]             det_r, da_r, db_r, dc_r, qd_r;
  logic [1:0]                cidx_r;
  logic [WW-1:0]             dn_r, dd_r, rem_r, quo_r;
  logic [6:0]                dcnt_r;
  logic                      neg_r, sat_r;
  logic [CW-1:0]             ca_r, cb_r, cc_r;
  fit_status_t               status_r;

  logic                      out_valid_r;
  logic [CW-1:0]             oa_r, ob_r, oc_r;
  fit_status_t               ostat_r;

  logic signed [MW-1:0]      mul_a, mul_b;
  logic signed [PW-1:0]      prod;
  logic                      add_en;
  logic [WW-1:0]             pp_sh;
  logic [WW-1:0]             quant_old, quant_new;
  logic [WW-1:0]             num_sel, anum, aden, an_sh, n2, d2;
  logic [WW-1:0]             rsh;
  logic                      r_ge;
  logic [WW-1:0]             lim;
  logic                      sat_now;
  logic [CW-1:0]             coef_val;
  logic                      out_take;
  logic                      out_load;

  // Sign-extend a solver operand to the wide word
  function automatic logic [WW-1:0] opnd_val(input opnd_t o);
    case (o)
      OP_X4:   return {{(WW-SX4W){sum_x4_r[SX4W-1]}}, sum_x4_r};
      OP_X3:   return {{(WW-SX3W){sum_x3_r[SX3W-1]}}, sum_x3_r};
      OP_X2:   return {{(WW-SX2W){sum_x2_r[SX2W-1]}}, sum_x2_r};
      OP_X1:   return {{(WW-SX1W){sum_x1_r[SX1W-1]}}, sum_x1_r};
      OP_N:    return {{(WW-CNTW){1'b0}}, cnt_r};
      OP_X2Y:  return {{(WW-SX2YW){sum_x2y_r[SX2YW-1]}}, sum_x2y_r};
      OP_XY:   return {{(WW-SXYW){sum_xy_r[SXYW-1]}}, sum_xy_r};
      OP_Y:    return {{(WW-SYW){sum_y_r[SYW-1]}}, sum_y_r};
      default: return {{(WW-1){1'b0}}, 1'b1};
    endcase
  endfunction

  assign add_en   = (cnt_r < CNTW'(MAX_POINTS));
  assign in_ready = (state_r == S_IDLE);
  assign out_take = out_valid_r && out_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_PT) begin
      case (step_r)
        3'd0: begin
          mul_a = {{(MW-XW){x_r[XW-1]}}, x_r};
          mul_b = {{(MW-XW){x_r[XW-1]}}, x_r};
        end
        3'd1: begin
          mul_a = {{(MW-XW){x_r[XW-1]}}, x_r};
          mul_b = {{(MW-YW){y_r[YW-1]}}, y_r};
        end
        3'd2: begin
          mul_a = {{(MW-X2W){x2_r[X2W-1]}}, x2_r};
          mul_b = {{(MW-X2W){x2_r[X2W-1]}}, x2_r};
        end
        3'd3: begin
          mul_a = {{(MW-X2W){x2_r[X2W-1]}}, x2_r};
          mul_b = {{(MW-XW){x_r[XW-1]}}, x_r};
        end
        default: begin
          mul_a = {{(MW-X2W){x2_r[X2W-1]}}, x2_r};
          mul_b = {{(MW-YW){y_r[YW-1]}}, y_r};
        end
      endcase
    end else begin
      mul_a = {1'b0, opa_r[{limb_a(mstep_r), 5'd0} +: LW]};
      mul_b = {1'b0, opb_r[{limb_b(mstep_r), 5'd0} +: LW]};
    end
  end

  assign prod  = mul_a * mul_b;
  assign pp_sh = {{(WW-64){1'b0}}, prod_r[63:0]} << {sh_r, 5'd0};

  // Running quantity plus or minus the finished term
  always_comb begin
    case (quant_r)
      Q_DET:   quant_old = det_r;
      Q_DA:    quant_old = da_r;
      Q_DB:    quant_old = db_r;
      Q_DC:    quant_old = dc_r;
      default: quant_old = qd_r;
    endcase
    if (term_r == 3'd0) quant_old = '0;
    quant_new = term_neg(quant_r, term_r) ? quant_old - acc_r : quant_old + acc_r;
  end

  // Prepare one rounded division: (2*|num|*2^sh + |den|) / (2*|den|)
  always_comb begin
    case (cidx_r)
      2'd0:    num_sel = da_r;
      2'd1:    num_sel = db_r;
      default: num_sel = dc_r;
    endcase
    anum = num_sel[WW-1] ? -num_sel : num_sel;
    aden = det_r[WW-1] ? -det_r : det_r;
    case (cidx_r)
      2'd0:    an_sh = anum << 24;
      2'd1:    an_sh = anum << 14;
      default: an_sh = anum << 4;
    endcase
    n2 = {an_sh[WW-2:0], 1'b0} + aden;
    d2 = {aden[WW-2:0], 1'b0};
  end

  // Restoring division step, remainder kept to the wide word
  assign rsh  = {rem_r[WW-2:0], dn_r[WW-1]};
  assign r_ge = (rsh >= dd_r);

  // Round-off result: clamp to Q16.16
  always_comb begin
    lim      = neg_r ? {{(WW-CW){1'b0}}, 32'h8000_0000} : {{(WW-CW){1'b0}}, 32'h7FFF_FFFF};
    sat_now  = (quo_r > lim);
    if (sat_now) coef_val = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else         coef_val = neg_r ? -quo_r[CW-1:0] : quo_r[CW-1:0];
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_PT;
      S_PT:     if (step_r == 3'd5) state_nxt = last_r ? S_CHK : S_IDLE;
      S_CHK:    state_nxt = (cnt_r < CNTW'(3)) ? S_DONE : S_LOAD;
      S_LOAD:   state_nxt = S_MUL;
      S_MUL:    if (mstep_r == 4'(LAST_LIMB + 1)) state_nxt = S_NEXT;
      S_NEXT: begin
        if (!stage_r)                       state_nxt = S_MUL;
        else if (term_r != term_last(quant_r)) state_nxt = S_LOAD;
        else if (quant_r == Q_QD)           state_nxt = S_DECIDE;
        else                                state_nxt = S_LOAD;
      end
      S_DECIDE: begin
        if (sum_x3_r == '0 || det_r == '0 || qd_r == '0) state_nxt = S_DONE;
        else                                              state_nxt = S_DSET;
      end
      S_DSET:   state_nxt = S_DIV;
      S_DIV:    if (dcnt_r == 7'd127) state_nxt = S_DFIN;
      S_DFIN:   state_nxt = (cidx_r == 2'd2) ? S_DONE : S_DSET;
      S_DONE:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x4_r  <= '0;
      sum_x3_r  <= '0;
      sum_x2_r  <= '0;
      sum_x1_r  <= '0;
      sum_y_r   <= '0;
      sum_xy_r  <= '0;
      sum_x2y_r <= '0;
      cnt_r     <= '0;
      step_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)      out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
      prod_r <= prod;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r    <= in_x_value;
            y_r    <= in_y_value;
            last_r <= in_last_point;
            step_r <= '0;
          end
        end
        S_PT: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd0: ;
            3'd1: begin
              x2_r <= prod_r[X2W-1:0];
              if (add_en) sum_x2_r <= sum_x2_r + prod_r[SX2W-1:0];
            end
            3'd2: if (add_en) sum_xy_r <= sum_xy_r + prod_r[SXYW-1:0];
            3'd3: if (add_en) sum_x4_r <= sum_x4_r + prod_r[SX4W-1:0];
            3'd4: if (add_en) sum_x3_r <= sum_x3_r + prod_r[SX3W-1:0];
            default: begin
              if (add_en) begin
                sum_x2y_r <= sum_x2y_r + prod_r[SX2YW-1:0];
                sum_x1_r  <= sum_x1_r + {{(SX1W-XW){x_r[XW-1]}}, x_r};
                sum_y_r   <= sum_y_r + {{(SYW-YW){y_r[YW-1]}}, y_r};
                cnt_r     <= cnt_r + CNTW'(1);
              end
            end
          endcase
        end
        S_CHK: begin
          quant_r  <= Q_DET;
          term_r   <= '0;
          ca_r     <= '0;
          cb_r     <= '0;
          cc_r     <= '0;
          status_r <= ST_FEW;
        end
        S_LOAD: begin
          opa_r   <= opnd_val(term_opnd(quant_r, term_r, 2'd0));
          opb_r   <= opnd_val(term_opnd(quant_r, term_r, 2'd1));
          acc_r   <= '0;
          mstep_r <= '0;
          stage_r <= 1'b0;
        end
        S_MUL: begin
          mstep_r <= mstep_r + 4'd1;
          sh_r    <= limb_a(mstep_r) + limb_b(mstep_r);
          if (mstep_r != 4'd0) acc_r <= acc_r + pp_sh;
        end
        S_NEXT: begin
          if (!stage_r) begin
            opa_r   <= acc_r;
            opb_r   <= opnd_val(term_opnd(quant_r, term_r, 2'd2));
            acc_r   <= '0;
            mstep_r <= '0;
            stage_r <= 1'b1;
          end else begin
            case (quant_r)
              Q_DET:   det_r <= quant_new;
              Q_DA:    da_r  <= quant_new;
              Q_DB:    db_r  <= quant_new;
              Q_DC:    dc_r  <= quant_new;
              default: qd_r  <= quant_new;
            endcase
            if (term_r == term_last(quant_r)) begin
              term_r  <= '0;
              quant_r <= quant_t'(3'(quant_r) + 3'd1);
            end else begin
              term_r <= term_r + 3'd1;
            end
          end
        end
        S_DECIDE: begin
          sat_r  <= 1'b0;
          cidx_r <= '0;
          if (sum_x3_r == '0 || det_r == '0)
            status_r <= (sum_x3_r != '0 && dc_r != '0) ? ST_NOFIT : ST_NOTUNIQ;
          else if (qd_r == '0)
            status_r <= ST_DEGEN;
          else
            status_r <= ST_OK;
        end
        S_DSET: begin
          dn_r   <= n2;
          dd_r   <= d2;
          rem_r  <= '0;
          quo_r  <= '0;
          dcnt_r <= '0;
          neg_r  <= num_sel[WW-1] ^ det_r[WW-1];
        end
        S_DIV: begin
          dn_r   <= {dn_r[WW-2:0], 1'b0};
          rem_r  <= r_ge ? rsh - dd_r : rsh;
          quo_r  <= {quo_r[WW-2:0], r_ge};
          dcnt_r <= dcnt_r + 7'd1;
        end
        S_DFIN: begin
          case (cidx_r)
            2'd0:    ca_r <= coef_val;
            2'd1:    cb_r <= coef_val;
            default: cc_r <= coef_val;
          endcase
          sat_r  <= sat_r | sat_now;
          cidx_r <= cidx_r + 2'd1;
          if (cidx_r == 2'd2 && (sat_r || sat_now)) status_r <= ST_DEGEN;
        end
        S_DONE: begin
          if (out_load) begin
            oa_r        <= ca_r;
            ob_r        <= cb_r;
            oc_r        <= cc_r;
            ostat_r     <= status_r;
            sum_x4_r    <= '0;
            sum_x3_r    <= '0;
            sum_x2_r    <= '0;
            sum_x1_r    <= '0;
            sum_y_r     <= '0;
            sum_xy_r    <= '0;
            sum_x2y_r   <= '0;
            cnt_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_coef_square   = oa_r;
  assign out_coef_linear   = ob_r;
  assign out_coef_constant = oc_r;
  assign out_fit_status    = ostat_r;

endmodule

// File: design/qlsf_checker.sv
// Port-level checks of the quadratic fit, bound to the top level.
module qlsf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic signed [qlsf_pkg::XW-1:0]    in_x_value,
  input logic signed [qlsf_pkg::YW-1:0]    in_y_value,
  input logic                              in_last_point,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [qlsf_pkg::CW-1:0]    out_coef_square,
  input logic signed [qlsf_pkg::CW-1:0]    out_coef_linear,
  input logic signed [qlsf_pkg::CW-1:0]    out_coef_constant,
  input logic [qlsf_pkg::SW-1:0]           out_fit_status
);
  import qlsf_pkg::*;

  // A result waiting for transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coef_square) &&
      $stable(out_coef_linear) && $stable(out_coef_constant) && $stable(out_fit_status))
    else $error("result changed while stalled");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fit_status <= SW'(ST_DEGEN))
    else $error("status code out of range");

  // Failed fits other than ST_DEGEN (zero quadratic determinant or saturation) carry zero coefficients
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fit_status == SW'(ST_FEW) || out_fit_status == SW'(ST_NOFIT) ||
      out_fit_status == SW'(ST_NOTUNIQ)) |->
      out_coef_square == '0 && out_coef_linear == '0 && out_coef_constant == '0)
    else $error("failed fit with nonzero coefficient");

  // A point transfer keeps the block busy next cycle
  a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a point transfer");

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the quadratic least-squares fit: directed table, then random sets.
`timescale 1ns / 100ps

module tb_top;
  import qlsf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] sq;
    logic signed [CW-1:0] lin;
    logic signed [CW-1:0] cst;
    fit_status_t          st;
  } fit_t;

  typedef struct {
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
    bit                   last;
    bit                   typed;
    fit_t                 fit;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [XW-1:0] in_x_value;
  logic signed [YW-1:0] in_y_value;
  logic                 in_last_point;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_coef_square;
  logic signed [CW-1:0] out_coef_linear;
  logic signed [CW-1:0] out_coef_constant;
  logic [SW-1:0]        out_fit_status;

  // Running sums of the set in progress
  longint acc_x4, acc_x3, acc_x2, acc_x1, acc_y, acc_xy, acc_x2y;
  int     acc_n;

  fit_t   fit_q[$];
  int     errors;
  int     idle_cycles;
  int     fits_seen;
  int     points_sent;
  bit     hold_req;
  bit     hold_done;
  bit     done_sending;

  quadratic_least_squares_fit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic wide_t prod3(longint a, longint b, longint c);
    wide_t r;
    r = wide_t'(a) * wide_t'(b);
    r = r * wide_t'(c);
    return r;
  endfunction

  function automatic wide_t det3(longint m[9]);
    wide_t d;
    d = prod3(m[0], m[4], m[8]) - prod3(m[0], m[5], m[7]);
    d = d - (prod3(m[1], m[3], m[8]) - prod3(m[1], m[5], m[6]));
    return d + (prod3(m[2], m[3], m[7]) - prod3(m[2], m[4], m[6]));
  endfunction

  // Round num * 2^sh / den to nearest, ties away from zero, clamp to Q16.16
  function automatic logic signed [CW-1:0] round_q16(wide_t num, wide_t den, int sh,
                                                     inout bit sat);
    logic [127:0] an, ad, dd, q, lim;
    bit neg;
    neg = num[127] != den[127];
    an = (num[127] ? -num : num) << sh;
    ad = den[127] ? -den : den;
    dd = ad << 1;
    q = (dd == 0) ? '1 : ((an << 1) + ad) / dd;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return neg ? -q[CW-1:0] : q[CW-1:0];
  endfunction

  function automatic void clear_sums();
    acc_x4 = 0; acc_x3 = 0; acc_x2 = 0; acc_x1 = 0;
    acc_y = 0; acc_xy = 0; acc_x2y = 0; acc_n = 0;
  endfunction

  // Fold one point into the sums; on a last point return the fit
  function automatic bit fold_point(logic signed [XW-1:0] xv, logic signed [YW-1:0] yv,
                                    bit last, output fit_t f);
    longint x, y, x2, n;
    longint m[9], ma[9], mb[9], mc[9], rhs[3];
    wide_t det, da, db, dc, qd;
    bit sat;
    x = xv; y = yv;
    f = '{sq: 0, lin: 0, cst: 0, st: ST_OK};
    if (acc_n < MAX_POINTS_DEF) begin
      x2 = x * x;
      acc_x4 += x2 * x2; acc_x3 += x2 * x; acc_x2 += x2; acc_x1 += x;
      acc_y += y; acc_xy += x * y; acc_x2y += x2 * y;
      acc_n++;
    end
    if (!last) return 1'b0;
    if (acc_n < 3) begin
      f.st = ST_FEW;
    end else begin
      n = acc_n;
      m = '{acc_x4, acc_x3, acc_x2, acc_x3, acc_x2, acc_x1, acc_x2, acc_x1, n};
      rhs = '{acc_x2y, acc_xy, acc_y};
      ma = m; mb = m; mc = m;
      for (int k = 0; k < 3; k++) begin
        ma[k*3] = rhs[k]; mb[k*3+1] = rhs[k]; mc[k*3+2] = rhs[k];
      end
      det = det3(m);
      dc = det3(mc);
      qd = prod3(acc_x4, acc_x2, 1) - prod3(acc_x3, acc_x3, 1);
      if (acc_x3 == 0 || det == 0) begin
        f.st = (acc_x3 != 0 && dc != 0) ? ST_NOFIT : ST_NOTUNIQ;
      end else if (qd == 0) begin
        f.st = ST_DEGEN;
      end else begin
        sat = 1'b0;
        da = det3(ma);
        db = det3(mb);
        f.sq = round_q16(da, det, 24, sat);
        f.lin = round_q16(db, det, 14, sat);
        f.cst = round_q16(dc, det, 4, sat);
        if (sat) f.st = ST_DEGEN;
      end
    end
    clear_sums();
    return 1'b1;
  endfunction

  // Offer one point, hold until transfer, then predict
  task automatic send_point(logic signed [XW-1:0] x, logic signed [YW-1:0] y, bit last,
                            bit typed, fit_t typed_fit);
    fit_t f;
    in_valid <= 1'b1;
    in_x_value <= x;
    in_y_value <= y;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    if (fold_point(x, y, last, f)) fit_q.push_back(typed ? typed_fit : f);
  endtask

  task automatic sender_gap();
    int g;
    int r;
    r = $urandom_range(99);
    g = (r < 60) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Random point, sometimes near the extremes or small
  task automatic rand_point(bit last);
    logic signed [XW-1:0] x;
    logic signed [YW-1:0] y;
    fit_t none;
    none = '{sq: 0, lin: 0, cst: 0, st: ST_OK};
    case ($urandom_range(3))
      0: begin x = $urandom_range(1) ? 12'sh7FF : 12'sh800; y = $urandom; end
      1: begin x = $signed(12'($urandom_range(64))) - 12'sd32; y = $urandom_range(255); end
      default: begin x = $urandom; y = $urandom; end
    endcase
    send_point(x, y, last, 1'b0, none);
  endtask

  // Receiver: random ready, with one long hold-off on request
  initial begin
    int len;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int c = 0; c < 3000; c++) @(posedge clk);
      end
      len = $urandom_range(12, 1);
      out_ready <= 1'b1;
      repeat (len) @(posedge clk);
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3);
      if (len > 0) begin
        out_ready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  // Compare each transferred fit with the oldest prediction
  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_valid && out_ready) begin
      fits_seen++;
      if (fit_q.size() == 0) begin
        $error("unexpected fit: status %0d", out_fit_status);
        errors++;
      end else begin
        e = fit_q.pop_front();
        if (out_coef_square !== e.sq) begin
          $error("coef_square exp %0d got %0d", e.sq, out_coef_square);
          errors++;
        end
        if (out_coef_linear !== e.lin) begin
          $error("coef_linear exp %0d got %0d", e.lin, out_coef_linear);
          errors++;
        end
        if (out_coef_constant !== e.cst) begin
          $error("coef_constant exp %0d got %0d", e.cst, out_coef_constant);
          errors++;
        end
        if (out_fit_status !== e.st) begin
          $error("fit_status exp %0d got %0d", e.st, out_fit_status);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    row_t rows[$];
    fit_t none, few, notuniq;
    int   len;
    none = '{sq: 0, lin: 0, cst: 0, st: ST_OK};
    few = '{sq: 0, lin: 0, cst: 0, st: ST_FEW};
    notuniq = '{sq: 0, lin: 0, cst: 0, st: ST_NOTUNIQ};
    errors = 0; fits_seen = 0; points_sent = 0; idle_cycles = 0;
    hold_req = 1'b0; hold_done = 1'b0; done_sending = 1'b0;
    clear_sums();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_value = '0;
    in_y_value = '0;
    in_last_point = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: single point, two points, all x zero, extremes, exact line,
    // two distinct abscissas only, exact parabola
    rows = '{
      '{12'sh800, 16'sh8000, 1, 1, few},
      '{12'sh7FF, 16'sh7FFF, 0, 0, none},
      '{12'sh800, 16'sh0000, 1, 1, few},
      '{12'sh000, 16'sd100, 0, 0, none},
      '{12'sh000, 16'sh7FFF, 0, 0, none},
      '{12'sh000, 16'sh8000, 1, 1, notuniq},
      '{12'sh7FF, 16'sh7FFF, 0, 0, none},
      '{12'sh800, 16'sh8000, 0, 0, none},
      '{12'sh400, 16'sh7FFF, 0, 0, none},
      '{12'shC00, 16'sh8000, 1, 0, none},
      '{-12'sd1024, -16'sd4096, 0, 0, none},
      '{12'sd0, 16'sd0, 0, 0, none},
      '{12'sd1024, 16'sd4096, 0, 0, none},
      '{12'sd512, 16'sd2048, 1, 0, none},
      '{12'sd256, 16'sd7, 0, 0, none},
      '{12'sd256, 16'sd9, 0, 0, none},
      '{-12'sd256, 16'sd3, 1, 0, none},
      '{12'sd1, 16'sd1, 0, 0, none},
      '{12'sd2, 16'sd4, 0, 0, none},
      '{12'sd3, 16'sd9, 1, 0, none}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed,
                                 rows[i].fit);

    // Pause until every fit of the directed part is in
    in_valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk);

    // Random sets: mostly short, a few tiny, a few past the point limit
    while (points_sent < 1120) begin
      case ($urandom_range(29))
        0: len = $urandom_range(300, 257);
        1, 2: len = $urandom_range(2, 1);
        default: len = $urandom_range(12, 3);
      endcase
      if (!hold_done && points_sent > 400) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      for (int k = 0; k < len; k++) begin
        rand_point(k == len - 1);
        if (points_sent > 200) sender_gap();
      end
    end
    in_valid <= 1'b0;
    done_sending = 1'b1;

    while (fit_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    $display("Sent %0d points over directed and random sets; %0d fits checked.",
             points_sent, fits_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
